[src/ille_pkg.sv]
package ille_pkg;

	typedef enum logic [2:0] {
		CMD_APPEND    = 3'd0,
		CMD_PUSH      = 3'd1,
		CMD_INSERT    = 3'd2,
		CMD_READ      = 3'd3,
		CMD_WRITE     = 3'd4,
		CMD_REMOVE    = 3'd5,
		CMD_POP_HEAD  = 3'd6,
		CMD_POP_TAIL  = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK_RD,
		S_WALK,
		S_NODE_RD,
		S_NODE,
		S_FIX_A,
		S_FIX_B,
		S_RESULT
	} state_t;

	localparam int unsigned CMD_W    = 3;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 9;

endpackage

[src/ille_if.sv]
interface ille_req_if;
	import ille_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [POS_W-1:0]   position;
	logic [VALUE_W-1:0] value;
	modport source (output valid, command, position, value, input ready);
	modport sink   (input valid, command, position, value, output ready);
endinterface

interface ille_rsp_if;
	import ille_pkg::*;
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  read_value;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  element_count;
	modport source (output valid, read_value, status, element_count, input ready);
	modport sink   (input valid, read_value, status, element_count, output ready);
endinterface

[src/ille_mem.sv]
module ille_mem #(
	parameter int unsigned DEPTH = 256,
	parameter int unsigned WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/indexed_linked_list_engine.sv]
// indexed_linked_list_engine: bounded doubly linked list of data words
//
// requests arrive on req (command, position, value); each request gives exactly
// one response on rsp (read_value, status, element_count). one request is in
// the engine at a time: req.ready is high only while the engine is idle.
//
// a rejected request goes from the decide state straight to the result state.
// append, push front and insert at the end write the new node without a walk;
// the pops read the node at the head or tail first. positional commands walk
// the next links from the head, one link per read and walk state pair through
// the registered read port of the link memory, so read, write, remove and
// insert take longer as the position grows. with the receiver ready the next
// request is taken once the response has been accepted.
//
// reset: the list is empty, head and tail hold the null marker, the free stack
// and the never-used mark are zero. node memories are not cleared; no entry is
// read before it is written.
//
// when the receiver stalls the response is held in the output register and no
// new request is taken until it has been delivered.
module indexed_linked_list_engine #(
	parameter int unsigned CAPACITY   = 256,
	parameter int unsigned DATA_WIDTH = 32
) (
	input logic clk,
	input logic arst_n,
	ille_req_if.sink   req,
	ille_rsp_if.source rsp
);
	import ille_pkg::*;

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (LW > POS_W) ? LW : POS_W;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);
	localparam logic [LW-1:0] CAP = LW'(CAPACITY);

	state_t state_q, state_d;

	// working registers
	logic [CMD_W-1:0]      cmd_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [LW-1:0]         head_q, tail_q, len_q, ftop_q, mark_q;
	logic [LW-1:0]         cur_q;   // walk pointer / target slot
	logic [LW-1:0]         new_q;   // allocated slot
	logic [POS_W:0]        cnt_q;   // links still to walk
	logic [LW-1:0]         p_q, n_q;
	logic [VALUE_W-1:0]    rv_q;
	logic [STATUS_W-1:0]   st_q;
	logic                  out_v_q;

	// position and length compared at a common width
	logic [PW-1:0]         pos_w, len_w;
	logic                  ins_walk;

	// memories
	logic                  nx_we, pv_we, dv_we, fs_we;
	logic [AW-1:0]         nx_wa, pv_wa, dv_wa, fs_wa;
	logic [LW-1:0]         nx_wd, pv_wd;
	logic [AW-1:0]         fs_wd;
	logic [DATA_WIDTH-1:0] dv_wd;
	logic [AW-1:0]         nx_ra, pv_ra, dv_ra, fs_ra;
	logic [LW-1:0]         nx_rd, pv_rd;
	logic [DATA_WIDTH-1:0] dv_rd;
	logic [AW-1:0]         fs_rd;

	ille_mem #(.DEPTH(CAPACITY), .WIDTH(LW)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
	ille_mem #(.DEPTH(CAPACITY), .WIDTH(LW)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
	ille_mem #(.DEPTH(CAPACITY), .WIDTH(DATA_WIDTH)) u_data (
		.clk(clk), .we(dv_we), .waddr(dv_wa), .wdata(dv_wd), .raddr(dv_ra), .rdata(dv_rd));
	ille_mem #(.DEPTH(CAPACITY), .WIDTH(AW)) u_free (
		.clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

	logic is_ins, is_pos, full;
	assign is_ins = (cmd_q == CMD_APPEND) || (cmd_q == CMD_PUSH) || (cmd_q == CMD_INSERT);
	assign is_pos = (cmd_q == CMD_READ) || (cmd_q == CMD_WRITE) || (cmd_q == CMD_REMOVE);
	assign full   = (ftop_q == '0) && (mark_q == CAP);

	assign pos_w    = PW'(pos_q);
	assign len_w    = PW'(len_q);
	// insert in the middle: walk to the target, its prev link comes from memory
	assign ins_walk = (cmd_q == CMD_INSERT) && (pos_w != len_w);

	// slot coming off the free stack or from the never-used mark
	logic [LW-1:0] alloc;
	assign alloc = (ftop_q != '0) ? LW'(fs_rd) : mark_q;

	assign req.ready         = (state_q == S_IDLE) && !out_v_q;
	assign rsp.valid         = out_v_q;
	assign rsp.read_value    = rv_q;
	assign rsp.status        = st_q;
	assign rsp.element_count = COUNT_W'(len_q);

	// read addresses: free stack top always, links at the current slot
	always_comb begin
		fs_ra = AW'(ftop_q - 1'b1);
		nx_ra = cur_q[AW-1:0];
		pv_ra = cur_q[AW-1:0];
		dv_ra = cur_q[AW-1:0];
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (req.valid && req.ready) state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = S_RESULT;
				if (is_ins) begin
					if (!((cmd_q == CMD_INSERT) && (pos_w > len_w)) && !full)
						state_d = ins_walk ? S_WALK_RD : S_NODE;
				end else if (is_pos) begin
					if (len_q != '0 && pos_w < len_w) state_d = S_WALK_RD;
				end else if (len_q != '0) begin
					state_d = S_NODE_RD;
				end
			end
			S_WALK_RD: state_d = (cnt_q == '0) ? S_NODE_RD : S_WALK;
			S_WALK:    state_d = S_WALK_RD;
			S_NODE_RD: state_d = S_NODE;
			S_NODE:    state_d = is_ins ? S_FIX_A : ((cmd_q == CMD_READ ||
				cmd_q == CMD_WRITE) ? S_RESULT : S_FIX_A);
			S_FIX_A:   state_d = S_FIX_B;
			S_FIX_B:   state_d = S_RESULT;
			S_RESULT:  state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// memory writes
	always_comb begin
		nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
		pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
		dv_we = 1'b0; dv_wa = '0; dv_wd = val_q;
		fs_we = 1'b0; fs_wa = ftop_q[AW-1:0]; fs_wd = cur_q[AW-1:0];
		case (state_q)
			S_NODE: begin
				if (is_ins) begin
					dv_we = 1'b1; dv_wa = new_q[AW-1:0];
					// new node: prev = neighbour before, next = cur_q (target or nil)
					nx_we = 1'b1; nx_wa = new_q[AW-1:0]; nx_wd = cur_q;
					pv_we = 1'b1; pv_wa = new_q[AW-1:0];
					pv_wd = ins_walk ? pv_rd : p_q;
				end else if (cmd_q == CMD_WRITE) begin
					dv_we = 1'b1; dv_wa = cur_q[AW-1:0];
				end
			end
			S_FIX_A: begin
				if (is_ins) begin
					if (p_q != NIL) begin
						nx_we = 1'b1; nx_wa = p_q[AW-1:0]; nx_wd = new_q;
					end
					if (cur_q != NIL) begin
						pv_we = 1'b1; pv_wa = cur_q[AW-1:0]; pv_wd = new_q;
					end
				end else begin
					if (p_q != NIL) begin
						nx_we = 1'b1; nx_wa = p_q[AW-1:0]; nx_wd = n_q;
					end
					if (n_q != NIL) begin
						pv_we = 1'b1; pv_wa = n_q[AW-1:0]; pv_wd = p_q;
					end
					fs_we = (ftop_q < CAP);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NIL;
			tail_q  <= NIL;
			len_q   <= '0;
			ftop_q  <= '0;
			mark_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			case (state_q)
				S_FIX_A: begin
					if (is_ins) begin
						if (p_q == NIL) head_q <= new_q;
						if (cur_q == NIL) tail_q <= new_q;
						len_q <= len_q + 1'b1;
					end else begin
						if (p_q == NIL) head_q <= n_q;
						if (n_q == NIL) tail_q <= p_q;
						if (len_q != '0) len_q <= len_q - 1'b1;
						if (ftop_q < CAP) ftop_q <= ftop_q + 1'b1;
					end
				end
				S_DECIDE: begin
					// claim the slot now for inserts that will succeed
					if (state_d != S_RESULT && is_ins) begin
						if (ftop_q != '0) ftop_q <= ftop_q - 1'b1;
						else mark_q <= mark_q + 1'b1;
					end
				end
				S_RESULT: out_v_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					cmd_q <= req.command;
					pos_q <= req.position;
					val_q <= DATA_WIDTH'(req.value);
					rv_q  <= '0;
					st_q  <= ST_OK;
				end
			end
			S_DECIDE: begin
				new_q <= alloc;
				cnt_q <= {1'b0, pos_q};
				if (is_ins) begin
					if ((cmd_q == CMD_INSERT) && (pos_w > len_w)) st_q <= ST_RANGE;
					else if (full) st_q <= ST_FULL;
					// neighbours for end inserts
					if (cmd_q == CMD_PUSH) begin
						cur_q <= head_q; p_q <= NIL;
					end else if (cmd_q == CMD_APPEND ||
						pos_w == len_w) begin
						cur_q <= NIL; p_q <= tail_q;
					end else begin
						cur_q <= head_q;
					end
					if (cmd_q == CMD_INSERT && pos_w != len_w &&
						pos_w <= len_w && !full) begin
						// walk to target, then prev comes from memory
						cnt_q <= {1'b0, pos_q};
					end
				end else if (is_pos) begin
					if (len_q == '0) st_q <= ST_EMPTY;
					else if (pos_w >= len_w) st_q <= ST_RANGE;
					cur_q <= head_q;
				end else begin
					if (len_q == '0) st_q <= ST_EMPTY;
					cur_q <= (cmd_q == CMD_POP_HEAD) ? head_q : tail_q;
				end
			end
			S_WALK_RD: if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
			S_WALK:    cur_q <= nx_rd;
			S_NODE_RD: ;
			S_NODE: begin
				if (!is_ins || ins_walk) p_q <= pv_rd;
				n_q <= nx_rd;
				if (cmd_q == CMD_READ || cmd_q == CMD_REMOVE ||
					cmd_q == CMD_POP_HEAD || cmd_q == CMD_POP_TAIL)
					rv_q <= VALUE_W'(dv_rd);
			end
			default: ;
		endcase
	end

	// a request is only taken with no response pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !out_v_q)
		else $error("request taken while response pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CAP)
		else $error("list length exceeds capacity");
	assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == '0 && state_q == S_IDLE) |-> (head_q == NIL && tail_q == NIL))
		else $error("empty list with live head or tail");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT) |=> out_v_q)
		else $error("response lost");
endmodule
